// File: rtl/lidar_door_detector_macros.svh
// ---------------------------------------------------------------------------
// lidar_door_detector_macros : assertion macros
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LIDAR_DOOR_DETECTOR_MACROS_SVH
`define LIDAR_DOOR_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define LDD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LDD_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LDD_ASSERT(name, prop, msg)
`define LDD_NEVER(name, cond, msg)
`endif
`endif

// File: rtl/ldd_pkg.sv
// ---------------------------------------------------------------------------
// ldd_pkg : shared types and constants
// Peak record, command record and register map of the door detector.
// ---------------------------------------------------------------------------
package ldd_pkg;
	localparam int COORD_W = 16;

	localparam logic [1:0] REG_JUMP     = 2'd0;
	localparam logic [1:0] REG_SUPPRESS = 2'd1;
	localparam logic [1:0] REG_DOOR_MIN = 2'd2;
	localparam logic [1:0] REG_DOOR_MAX = 2'd3;

	localparam logic [15:0] JUMP_RST     = 16'd1000;
	localparam logic [15:0] SUPPRESS_RST = 16'd500;
	localparam logic [15:0] DOOR_MIN_RST = 16'd800;
	localparam logic [15:0] DOOR_MAX_RST = 16'd1200;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] b;
	} peak_t;

	// one unit of work for the back end
	typedef struct packed {
		logic  offer; // candidate peak to be checked and stored
		logic  eos;   // scan ends after this command
		peak_t pk;
	} cmd_t;
endpackage

// File: rtl/ldd_front.sv
// ---------------------------------------------------------------------------
// ldd_front : point intake
// Keeps the previous point, detects range jumps and issues commands.
// ---------------------------------------------------------------------------
module ldd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic        [15:0] point_range,
	input  logic signed [15:0] point_bearing,
	input  logic               end_of_scan,
	input  logic        [15:0] jump_threshold,
	output logic               push,
	output ldd_pkg::cmd_t      cmd
);
	import ldd_pkg::*;

	logic signed [15:0] prev_x_q, prev_y_q, prev_b_q;
	logic        [15:0] prev_r_q;
	logic               have_prev_q;
	logic        [15:0] gap;
	logic               jump;

	always_comb begin
		gap  = (prev_r_q > point_range) ? prev_r_q - point_range : point_range - prev_r_q;
		jump = have_prev_q && (gap > jump_threshold);
		cmd.offer = jump;
		cmd.eos   = end_of_scan;
		if (prev_r_q < point_range) begin
			cmd.pk = '{x: prev_x_q, y: prev_y_q, b: prev_b_q};
		end else begin
			cmd.pk = '{x: point_x, y: point_y, b: point_bearing};
		end
		push = accept && (jump || end_of_scan);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_b_q    <= '0;
			prev_r_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (end_of_scan) begin
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				prev_b_q    <= '0;
				prev_r_q    <= '0;
				have_prev_q <= 1'b0;
			end else begin
				prev_x_q    <= point_x;
				prev_y_q    <= point_y;
				prev_b_q    <= point_bearing;
				prev_r_q    <= point_range;
				have_prev_q <= 1'b1;
			end
		end
	end
endmodule

// File: rtl/ldd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ldd_cmd_fifo : command queue
// Two-entry queue decoupling point intake from peak processing.
// ---------------------------------------------------------------------------
module ldd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ldd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          not_empty,
	output logic          full,
	output ldd_pkg::cmd_t head
);
	import ldd_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// File: rtl/ldd_back.sv
// ---------------------------------------------------------------------------
// ldd_back : peak store and door search
// Suppression check, peak storage and pairwise door search through one
// pipelined squared-distance unit.
// ---------------------------------------------------------------------------
module ldd_back #(
	parameter int MAX_PEAKS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  ldd_pkg::cmd_t      cmd,
	output logic               pop,
	input  logic        [15:0] suppress_radius,
	input  logic        [15:0] door_min_width,
	input  logic        [15:0] door_max_width,
	output logic               result_valid,
	output logic signed [15:0] first_x,
	output logic signed [15:0] first_y,
	output logic signed [15:0] first_bearing,
	output logic signed [15:0] second_x,
	output logic signed [15:0] second_y,
	output logic signed [15:0] second_bearing,
	output logic               door_valid,
	output logic               peak_overflow,
	output logic               last_result
);
	import ldd_pkg::*;

	localparam int CW = $clog2(MAX_PEAKS + 1);
	localparam int IW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_PEAKS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUPP = 2'd1;
	localparam logic [1:0] S_PAIR = 2'd2;

	peak_t mem [MAX_PEAKS];

	logic [1:0]    state_q;
	cmd_t          cand_q;
	logic [CW-1:0] cnt_q, iss_q, pi_q, pj_q;
	logic          hit_q, ovf_q, pend_q;
	peak_t         pend_a_q, pend_b_q;
	logic [31:0]   r2_q, lo_q, hi_q;

	// distance pipeline
	logic          v_s1, v_s2, v_s3;
	peak_t         a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic signed [16:0] dx_s2, dy_s2;
	logic [31:0]   sx_s3, sy_s3;
	logic signed [33:0] px, py;
	logic [32:0]   sum;
	logic          in_band, near;

	logic          issue, pipe_empty, supp_done, pair_done;
	logic [CW-1:0] ra, rb;

	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign supp_done  = (state_q == S_SUPP) && (iss_q == cnt_q) && pipe_empty;
	assign pair_done  = (state_q == S_PAIR) && (pj_q >= cnt_q) && pipe_empty;
	assign issue      = ((state_q == S_SUPP) && (iss_q < cnt_q)) ||
	                    ((state_q == S_PAIR) && (pj_q < cnt_q));
	assign ra         = (state_q == S_SUPP) ? iss_q : pi_q;
	assign rb         = pj_q;
	assign pop        = (state_q == S_IDLE) && cmd_avail;

	assign px      = 34'(dx_s2) * 34'(dx_s2);
	assign py      = 34'(dy_s2) * 34'(dy_s2);
	assign sum     = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign near    = sum < {1'b0, r2_q};
	assign in_band = (sum >= {1'b0, lo_q}) && (sum <= {1'b0, hi_q});

	always_ff @(posedge clk) begin
		r2_q <= 32'(suppress_radius) * 32'(suppress_radius);
		lo_q <= 32'(door_min_width) * 32'(door_min_width);
		hi_q <= 32'(door_max_width) * 32'(door_max_width);

		a_s1 <= mem[ra[IW-1:0]];
		b_s1 <= (state_q == S_SUPP) ? cand_q.pk : mem[rb[IW-1:0]];
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		dx_s2 <= 17'(a_s1.x) - 17'(b_s1.x);
		dy_s2 <= 17'(a_s1.y) - 17'(b_s1.y);
		a_s3  <= a_s2;
		b_s3  <= b_s2;
		sx_s3 <= px[31:0];
		sy_s3 <= py[31:0];

		if (supp_done && !hit_q && (cnt_q < MAXC) && cand_q.offer) begin
			mem[cnt_q[IW-1:0]] <= cand_q.pk;
		end
		if (pop) begin
			cand_q <= cmd;
		end
		if ((state_q == S_PAIR) && v_s3 && in_band) begin
			pend_a_q <= a_s3;
			pend_b_q <= b_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			iss_q        <= '0;
			pi_q         <= '0;
			pj_q         <= '0;
			hit_q        <= 1'b0;
			ovf_q        <= 1'b0;
			pend_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1         <= issue;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						hit_q  <= 1'b0;
						iss_q  <= '0;
						pi_q   <= '0;
						pj_q   <= CW'(1);
						pend_q <= 1'b0;
						state_q <= cmd.offer ? S_SUPP : S_PAIR;
					end
				end
				S_SUPP: begin
					if (issue) iss_q <= iss_q + CW'(1);
					if (v_s3 && near) hit_q <= 1'b1;
					if (supp_done) begin
						if (!hit_q) begin
							if (cnt_q < MAXC) cnt_q <= cnt_q + CW'(1);
							else              ovf_q <= 1'b1;
						end
						state_q <= cand_q.eos ? S_PAIR : S_IDLE;
					end
				end
				S_PAIR: begin
					if (issue) begin
						if (pj_q + CW'(1) < cnt_q) begin
							pj_q <= pj_q + CW'(1);
						end else begin
							pi_q <= pi_q + CW'(1);
							pj_q <= pi_q + CW'(2);
						end
					end
					if (v_s3 && in_band) begin
						pend_q <= 1'b1;
						// older door leaves as soon as a newer one is found
						if (pend_q) result_valid <= 1'b1;
					end
					if (pair_done) begin
						result_valid <= 1'b1;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register: loaded with the pending door or the end marker
	always_ff @(posedge clk) begin
		if (((state_q == S_PAIR) && v_s3 && in_band && pend_q) || pair_done) begin
			first_x        <= pend_q ? pend_a_q.x : '0;
			first_y        <= pend_q ? pend_a_q.y : '0;
			first_bearing  <= pend_q ? pend_a_q.b : '0;
			second_x       <= pend_q ? pend_b_q.x : '0;
			second_y       <= pend_q ? pend_b_q.y : '0;
			second_bearing <= pend_q ? pend_b_q.b : '0;
			door_valid     <= pend_q;
			peak_overflow  <= ovf_q;
			last_result    <= pair_done;
		end
	end
endmodule

// File: rtl/lidar_door_detector.sv
// ---------------------------------------------------------------------------
// lidar_door_detector : door finder for lidar scans
// Marks range-jump peaks, suppresses near duplicates and reports peak pairs
// whose spacing lies in the door band at the end of every scan.
// ---------------------------------------------------------------------------
// A point transfer happens on a clock edge with start high and busy low.
// Ordinary points go straight to the previous-point register; a point that
// makes a peak or ends a scan places one command in a two-entry queue, and
// busy is raised only while that queue is full. The back end checks a peak
// against the n peaks already stored through a three-stage squared-distance
// pipeline, one stored peak per cycle. At end of scan it walks every pair,
// one per cycle, through the same pipeline. Results cannot be held off:
// each appears for exactly one cycle with result_valid high and must be
// taken then. A scan gives its doors in pair order, the last one flagged by
// last_result; a scan without door gives one marker result (door_valid low,
// all coordinates zero). peak_overflow is high on every result of a scan in
// which a peak was lost for lack of storage. Registers on the APB port
// (4 byte stride): jump threshold, suppression radius, least and greatest
// door width, all 16-bit millimetres; write them only while the block idles.
// ---------------------------------------------------------------------------
`include "lidar_door_detector_macros.svh"

module lidar_door_detector #(
	parameter int MAX_PEAKS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [3:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready,
	// point intake
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic        [15:0] point_range,
	input  logic signed [15:0] point_bearing,
	input  logic               end_of_scan,
	// results
	output logic               result_valid,
	output logic signed [15:0] first_x,
	output logic signed [15:0] first_y,
	output logic signed [15:0] first_bearing,
	output logic signed [15:0] second_x,
	output logic signed [15:0] second_y,
	output logic signed [15:0] second_bearing,
	output logic               door_valid,
	output logic               peak_overflow,
	output logic               last_result
);
	import ldd_pkg::*;

	logic [15:0] jump_q, supp_q, dmin_q, dmax_q;
	logic        cfg_wr;
	logic        accept, push, pop, q_avail, q_full;
	cmd_t        push_cmd, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = start && !busy;
	assign busy   = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q <= JUMP_RST;
			supp_q <= SUPPRESS_RST;
			dmin_q <= DOOR_MIN_RST;
			dmax_q <= DOOR_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_JUMP:     jump_q <= pwdata[15:0];
				REG_SUPPRESS: supp_q <= pwdata[15:0];
				REG_DOOR_MIN: dmin_q <= pwdata[15:0];
				REG_DOOR_MAX: dmax_q <= pwdata[15:0];
				default:      jump_q <= jump_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_JUMP:     prdata = {16'd0, jump_q};
			REG_SUPPRESS: prdata = {16'd0, supp_q};
			REG_DOOR_MIN: prdata = {16'd0, dmin_q};
			REG_DOOR_MAX: prdata = {16'd0, dmax_q};
			default:      prdata = '0;
		endcase
	end

	ldd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_range    (point_range),
		.point_bearing  (point_bearing),
		.end_of_scan    (end_of_scan),
		.jump_threshold (jump_q),
		.push           (push),
		.cmd            (push_cmd)
	);

	ldd_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.not_empty (q_avail),
		.full      (q_full),
		.head      (head)
	);

	ldd_back #(.MAX_PEAKS(MAX_PEAKS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_avail       (q_avail),
		.cmd             (head),
		.pop             (pop),
		.suppress_radius (supp_q),
		.door_min_width  (dmin_q),
		.door_max_width  (dmax_q),
		.result_valid    (result_valid),
		.first_x         (first_x),
		.first_y         (first_y),
		.first_bearing   (first_bearing),
		.second_x        (second_x),
		.second_y        (second_y),
		.second_bearing  (second_bearing),
		.door_valid      (door_valid),
		.peak_overflow   (peak_overflow),
		.last_result     (last_result)
	);

	// a marker result is always the last of its scan and carries no peaks
	`LDD_ASSERT(a_marker_last, (result_valid && !door_valid) |-> (last_result && first_x == 16'd0 && second_x == 16'd0), "marker result malformed")
	// commands are only queued on a transfer, never into a full queue
	`LDD_NEVER(a_push_full, push && q_full, "command pushed into full queue")
	// back end takes nothing from an empty queue
	`LDD_NEVER(a_pop_empty, pop && !q_avail, "pop from empty queue")
endmodule
